// ----- sv/assert_macros.svh -----
// assertion helper macros for the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication, checked out of reset
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ----- sv/obpc_pkg.sv -----
// shared constants and register codes of the oriented box point counter
package obpc_pkg;

  localparam int DEF_COORD_BITS     = 18;
  localparam int DEF_COEF_FRAC_BITS = 14;
  localparam int DEF_MAX_POINTS     = 131072;

  localparam int CFG_IDX_BITS    = 3;
  localparam int MIN_PTS_BITS    = 18;
  localparam int COUNT_OUT_BITS  = 18;
  localparam int OUT_TDATA_W     = 24;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_ROT_ROW0   = 3'd0,
    REG_ROT_ROW1   = 3'd1,
    REG_ROT_ROW2   = 3'd2,
    REG_BOX_ORIGIN = 3'd3,
    REG_X_BOUNDS   = 3'd4,
    REG_Y_BOUNDS   = 3'd5,
    REG_Z_BOUNDS   = 3'd6,
    REG_MIN_POINTS = 3'd7
  } cfg_reg_t;

endpackage

// ----- sv/obpc_cfg_regs.sv -----
// configuration register file, write only
module obpc_cfg_regs import obpc_pkg::*; #(
  parameter int COORD_BITS     = DEF_COORD_BITS,
  parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS,
  parameter int CFG_W          = 54
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [CFG_W-1:0]            cfg_wdata,
  output logic [3*(COEF_FRAC_BITS+2)-1:0] rot_row0_r,
  output logic [3*(COEF_FRAC_BITS+2)-1:0] rot_row1_r,
  output logic [3*(COEF_FRAC_BITS+2)-1:0] rot_row2_r,
  output logic [3*COORD_BITS-1:0]     box_origin_r,
  output logic [2*COORD_BITS-1:0]     x_bounds_r,
  output logic [2*COORD_BITS-1:0]     y_bounds_r,
  output logic [2*COORD_BITS-1:0]     z_bounds_r,
  output logic [MIN_PTS_BITS-1:0]     min_points_r
);

  localparam int COEF_BITS = COEF_FRAC_BITS + 2;
  localparam int ROW_W     = 3 * COEF_BITS;

  // identity matrix: one on the diagonal
  localparam logic [ROW_W-1:0] ROW0_RST = ROW_W'(1) << COEF_FRAC_BITS;
  localparam logic [ROW_W-1:0] ROW1_RST = ROW_W'(1) << (COEF_FRAC_BITS + COEF_BITS);
  localparam logic [ROW_W-1:0] ROW2_RST = ROW_W'(1) << (COEF_FRAC_BITS + 2*COEF_BITS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_row0_r   <= ROW0_RST;
      rot_row1_r   <= ROW1_RST;
      rot_row2_r   <= ROW2_RST;
      box_origin_r <= '0;
      x_bounds_r   <= '0;
      y_bounds_r   <= '0;
      z_bounds_r   <= '0;
      min_points_r <= MIN_PTS_BITS'(1);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ROT_ROW0:   rot_row0_r   <= cfg_wdata[ROW_W-1:0];
        REG_ROT_ROW1:   rot_row1_r   <= cfg_wdata[ROW_W-1:0];
        REG_ROT_ROW2:   rot_row2_r   <= cfg_wdata[ROW_W-1:0];
        REG_BOX_ORIGIN: box_origin_r <= cfg_wdata[3*COORD_BITS-1:0];
        REG_X_BOUNDS:   x_bounds_r   <= cfg_wdata[2*COORD_BITS-1:0];
        REG_Y_BOUNDS:   y_bounds_r   <= cfg_wdata[2*COORD_BITS-1:0];
        REG_Z_BOUNDS:   z_bounds_r   <= cfg_wdata[2*COORD_BITS-1:0];
        REG_MIN_POINTS: min_points_r <= cfg_wdata[MIN_PTS_BITS-1:0];
        default:        min_points_r <= min_points_r;
      endcase
    end
  end

endmodule

// ----- sv/obpc_xform.sv -----
// origin subtract and nine coefficient products, registered
module obpc_xform import obpc_pkg::*; #(
  parameter int COORD_BITS     = DEF_COORD_BITS,
  parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic [3*COORD_BITS-1:0]               point,
  input  logic [3*COORD_BITS-1:0]               box_origin,
  input  logic [3*(COEF_FRAC_BITS+2)-1:0]       rot_row0,
  input  logic [3*(COEF_FRAC_BITS+2)-1:0]       rot_row1,
  input  logic [3*(COEF_FRAC_BITS+2)-1:0]       rot_row2,
  output logic signed [COORD_BITS+COEF_FRAC_BITS+2:0] prod_r [3][3]
);

  localparam int COEF_BITS = COEF_FRAC_BITS + 2;
  localparam int DIFF_W    = COORD_BITS + 1;
  localparam int PROD_W    = DIFF_W + COEF_BITS;

  logic signed [DIFF_W-1:0]    diff [3];
  logic signed [COEF_BITS-1:0] coef [3][3];
  logic signed [PROD_W-1:0]    prod_nxt [3][3];
  logic [3*COEF_BITS-1:0]      rows [3];

  assign rows[0] = rot_row0;
  assign rows[1] = rot_row1;
  assign rows[2] = rot_row2;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      diff[j] = DIFF_W'(signed'(point[j*COORD_BITS +: COORD_BITS]))
              - DIFF_W'(signed'(box_origin[j*COORD_BITS +: COORD_BITS]));
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        coef[i][j]     = signed'(rows[i][j*COEF_BITS +: COEF_BITS]);
        prod_nxt[i][j] = PROD_W'(diff[j]) * PROD_W'(coef[i][j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
    end
  end

endmodule

// ----- sv/obpc_axis_check.sv -----
// one local axis: sum of three products against scaled inclusive bounds
module obpc_axis_check import obpc_pkg::*; #(
  parameter int COORD_BITS     = DEF_COORD_BITS,
  parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
  input  logic signed [COORD_BITS+COEF_FRAC_BITS+2:0] prod [3],
  input  logic [2*COORD_BITS-1:0]                     bounds,
  output logic                                        in_range
);

  localparam int PROD_W = COORD_BITS + COEF_FRAC_BITS + 3;
  localparam int SUM_W  = PROD_W + 2;

  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] lo;
  logic signed [SUM_W-1:0] hi;

  always_comb begin
    sum = SUM_W'(prod[0]) + SUM_W'(prod[1]) + SUM_W'(prod[2]);
    // bounds scaled up by the coefficient fraction
    lo  = SUM_W'(signed'({bounds[COORD_BITS-1:0], {COEF_FRAC_BITS{1'b0}}}));
    hi  = SUM_W'(signed'({bounds[2*COORD_BITS-1:COORD_BITS], {COEF_FRAC_BITS{1'b0}}}));
    in_range = (sum >= lo) && (sum <= hi);
  end

endmodule

// ----- sv/oriented_box_point_counter_core.sv -----
// oriented box point counter: rotate, box test and frame count of lidar points
// throughput: one word per cycle, set by the three-stage register pipeline
// (input register, product register, result register), stalls only on out_tready
// reset (rst_n low, synchronous): pipeline empty, count zero, identity rotation,
// zero origin and bounds, min_points one
`include "assert_macros.svh"

module oriented_box_point_counter_core import obpc_pkg::*; #(
  parameter int COORD_BITS     = DEF_COORD_BITS,
  parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS,
  parameter int MAX_POINTS     = DEF_MAX_POINTS
) (
  input  logic clk,
  input  logic rst_n,
  // input stream
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // tdata: px, py, pz (signed), zero padded to bytes
  input  logic [((3*COORD_BITS+7)/8)*8-1:0]     in_tdata,
  input  logic                                  in_tlast,   // last_point
  // result stream
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // tdata: inside_res, running_count, obstacle, zero padded
  output logic [OUT_TDATA_W-1:0]                out_tdata,
  output logic                                  out_tlast,  // frame_done
  // configuration write port
  input  logic                                  cfg_we,
  input  logic [CFG_IDX_BITS-1:0]               cfg_index,
  input  logic [((COEF_FRAC_BITS+2 > COORD_BITS) ? 3*(COEF_FRAC_BITS+2)
                 : 3*COORD_BITS)-1:0]           cfg_wdata
);

  localparam int COEF_BITS = COEF_FRAC_BITS + 2;
  localparam int ROW_W     = 3 * COEF_BITS;
  localparam int PT_W      = 3 * COORD_BITS;
  localparam int CFG_W     = (COEF_BITS > COORD_BITS) ? 3*COEF_BITS : 3*COORD_BITS;
  localparam int PROD_W    = COORD_BITS + COEF_FRAC_BITS + 3;
  localparam int CNT_W     = $clog2(MAX_POINTS + 1);

  // configuration
  logic [ROW_W-1:0]          rot_row0, rot_row1, rot_row2;
  logic [PT_W-1:0]           box_origin;
  logic [2*COORD_BITS-1:0]   x_bounds, y_bounds, z_bounds;
  logic [MIN_PTS_BITS-1:0]   min_points;

  obpc_cfg_regs #(
    .COORD_BITS     (COORD_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS),
    .CFG_W          (CFG_W)
  ) u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .rot_row0_r   (rot_row0),
    .rot_row1_r   (rot_row1),
    .rot_row2_r   (rot_row2),
    .box_origin_r (box_origin),
    .x_bounds_r   (x_bounds),
    .y_bounds_r   (y_bounds),
    .z_bounds_r   (z_bounds),
    .min_points_r (min_points)
  );

  // pipeline advance: a stage moves when it is empty or the next one moves
  logic en0, en1, en2;
  logic v0_r, v1_r, out_valid_r;

  assign en2       = !out_valid_r || out_tready;
  assign en1       = !v1_r || en2;
  assign en0       = !v0_r || en1;
  assign in_tready = en0;

  // stage 0: input word register
  logic [PT_W-1:0] point_r;
  logic            last0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en0) begin
      v0_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en0 && in_tvalid) begin
      point_r <= in_tdata[PT_W-1:0];
      last0_r <= in_tlast;
    end
  end

  // stage 1: origin subtract and coefficient products
  logic signed [PROD_W-1:0] prod [3][3];
  logic                     last1_r;

  obpc_xform #(
    .COORD_BITS     (COORD_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_xform (
    .clk        (clk),
    .en         (en1 && v0_r),
    .point      (point_r),
    .box_origin (box_origin),
    .rot_row0   (rot_row0),
    .rot_row1   (rot_row1),
    .rot_row2   (rot_row2),
    .prod_r     (prod)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en1) begin
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && v0_r) begin
      last1_r <= last0_r;
    end
  end

  // stage 2: per-axis sums and bound compares, frame count
  logic [2:0] axis_in;
  logic [2*COORD_BITS-1:0] bounds [3];

  assign bounds[0] = x_bounds;
  assign bounds[1] = y_bounds;
  assign bounds[2] = z_bounds;

  for (genvar g = 0; g < 3; g++) begin : g_axis
    obpc_axis_check #(
      .COORD_BITS     (COORD_BITS),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_axis (
      .prod     (prod[g]),
      .bounds   (bounds[g]),
      .in_range (axis_in[g])
    );
  end

  logic             pt_in_box;
  logic [CNT_W-1:0] count_r, count_nxt, count_new;
  logic [31:0]      count_ext;
  logic             obstacle;

  always_comb begin
    pt_in_box = &axis_in;
    count_new = count_r;
    // count holds once it reaches the ceiling
    if (pt_in_box && (count_r < CNT_W'(MAX_POINTS))) begin
      count_new = count_r + CNT_W'(1);
    end
    count_ext = 32'(count_new);
    obstacle  = last1_r && (count_ext >= 32'(min_points));
    count_nxt = last1_r ? '0 : count_new;
  end

  logic [OUT_TDATA_W-1:0] out_data_r;
  logic                   out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else if (en2) begin
      out_valid_r <= v1_r;
      if (v1_r) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && v1_r) begin
      out_data_r <= OUT_TDATA_W'({obstacle, count_ext[COUNT_OUT_BITS-1:0], pt_in_box});
      out_last_r <= last1_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // checks
  `ASSERT_IMP(a_obstacle_only_on_last, clk, rst_n,
              out_valid_r && out_data_r[COUNT_OUT_BITS+1], out_last_r)
  `ASSERT_IMP(a_count_ceiling, clk, rst_n, 1'b1, count_r <= CNT_W'(MAX_POINTS))
  `ASSERT_NXT(a_count_cleared_after_frame, clk, rst_n,
              en2 && v1_r && last1_r, count_r == '0)

endmodule

// ----- verif/testbench.sv -----
// self-checking testbench for the oriented box point counter core
`timescale 1ns / 100ps

module testbench;
  import obpc_pkg::*;

  localparam int CB       = DEF_COORD_BITS;
  localparam int FB       = DEF_COEF_FRAC_BITS;
  localparam int KB       = DEF_COEF_FRAC_BITS + 2;
  localparam int CAP      = DEF_MAX_POINTS;
  localparam int IN_W     = ((3 * CB + 7) / 8) * 8;
  localparam int CFG_W    = (KB > CB) ? 3 * KB : 3 * CB;
  localparam int LIMIT    = 1000000;
  localparam int IDLE_PCT = 34;
  localparam int CALM_POINTS = 100;

  // one lidar point as it goes into the block
  typedef struct {
    logic signed [CB-1:0] px;
    logic signed [CB-1:0] py;
    logic signed [CB-1:0] pz;
    logic                 last;
  } lidar_point_t;

  // what the block should say about one point
  typedef struct {
    logic                      in_box;
    logic [COUNT_OUT_BITS-1:0] tally;
    logic                      done;
    logic                      obstacle;
  } box_verdict_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  // fields from bit 0 up: px, py, pz, zero pad
  logic [IN_W-1:0] in_tdata;
  logic in_tlast;
  logic out_tvalid;
  logic out_tready;
  // fields from bit 0 up: inside_res, running_count, obstacle, zero pad
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic out_tlast;
  logic cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  // mirror of the block's registers and frame count
  logic [3*KB-1:0]       rot_m [3];
  logic [3*CB-1:0]       origin_m;
  logic [2*CB-1:0]       bounds_m [3];
  logic [MIN_PTS_BITS-1:0] min_points_m;
  logic [COUNT_OUT_BITS-1:0] frame_count;

  lidar_point_t point_queue[$];
  box_verdict_t verdicts_due[$];
  int points_left = 0;
  int mismatches  = 0;
  int cycle_count = 0;
  bit point_taken = 1'b0;
  bit calm        = 1'b0;   // no idling on either side while set

  oriented_box_point_counter_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(string what, longint want, longint got);
    if (mismatches < 50) begin
      $display("mismatch on %s: expected %0d, got %0d (cycle %0d)", what, want, got,
               cycle_count);
    end
    mismatches++;
  endtask

  function automatic bit idle_roll();
    return !calm && ($urandom_range(99) < IDLE_PCT);
  endfunction

  // rotate the point into box coordinates, test the box, update the frame count
  task automatic classify_point(input lidar_point_t p);
    logic signed [CB-1:0] pc [3];
    longint d [3];
    longint acc, lo, hi;
    logic hit;
    logic [COUNT_OUT_BITS-1:0] tally;
    box_verdict_t v;
    pc[0] = p.px;
    pc[1] = p.py;
    pc[2] = p.pz;
    // difference to the origin is exact, one bit wider than a coordinate
    for (int a = 0; a < 3; a++) begin
      d[a] = longint'(pc[a]) - longint'($signed(origin_m[a*CB +: CB]));
    end
    hit = 1'b1;
    for (int r = 0; r < 3; r++) begin
      acc = 0;
      for (int k = 0; k < 3; k++) begin
        acc += d[k] * longint'($signed(rot_m[r][k*KB +: KB]));
      end
      // bounds carry the same fraction bits as the rotated sum
      lo = longint'($signed(bounds_m[r][CB-1:0])) * (longint'(1) << FB);
      hi = longint'($signed(bounds_m[r][2*CB-1:CB])) * (longint'(1) << FB);
      if (acc < lo || acc > hi) hit = 1'b0;
    end
    tally = frame_count;
    if (hit && tally < CAP) tally++;
    v.in_box   = hit;
    v.tally    = tally;
    v.done     = p.last;
    v.obstacle = p.last && (tally >= min_points_m);
    frame_count = p.last ? '0 : tally;
    verdicts_due.insert(verdicts_due.size(), v);
  endtask

  // register write, mirrored at once since the block is idle
  task automatic write_reg(input cfg_reg_t r, input logic [CFG_W-1:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_wdata <= v;
    case (r)
      REG_ROT_ROW0:   rot_m[0]     = v[3*KB-1:0];
      REG_ROT_ROW1:   rot_m[1]     = v[3*KB-1:0];
      REG_ROT_ROW2:   rot_m[2]     = v[3*KB-1:0];
      REG_BOX_ORIGIN: origin_m     = v[3*CB-1:0];
      REG_X_BOUNDS:   bounds_m[0]  = v[2*CB-1:0];
      REG_Y_BOUNDS:   bounds_m[1]  = v[2*CB-1:0];
      REG_Z_BOUNDS:   bounds_m[2]  = v[2*CB-1:0];
      default:        min_points_m = v[MIN_PTS_BITS-1:0];
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_point(input int x, input int y, input int z, input bit last);
    lidar_point_t p;
    p.px = CB'(x);
    p.py = CB'(y);
    p.pz = CB'(z);
    p.last = last;
    point_queue.insert(point_queue.size(), p);
    points_left++;
  endtask

  // every point accepted and every verdict seen
  task automatic wait_idle();
    while (points_left != 0 || verdicts_due.size() != 0) @(posedge clk);
    repeat (5) @(negedge clk);
  endtask

  function automatic logic [CFG_W-1:0] row3(input int cx, input int cy, input int cz);
    return CFG_W'({KB'(cz), KB'(cy), KB'(cx)});
  endfunction

  function automatic logic [CFG_W-1:0] xyz(input int x, input int y, input int z);
    return CFG_W'({CB'(z), CB'(y), CB'(x)});
  endfunction

  function automatic logic [CFG_W-1:0] range2(input int lo, input int hi);
    return CFG_W'({CB'(hi), CB'(lo)});
  endfunction

  // one rotation row in one of four flavors
  function automatic logic [CFG_W-1:0] pick_row(input int style, input int r);
    logic [KB-1:0] c [3];
    for (int k = 0; k < 3; k++) begin
      case (style)
        0: c[k] = (k == r) ? ($urandom_range(1) ? KB'(1 << FB) : KB'(-(1 << FB))) : '0;
        1: c[k] = KB'($urandom_range(2 << FB) - (1 << FB));
        2: c[k] = KB'($urandom);
        default: begin
          case ($urandom_range(3))
            0: c[k] = {1'b1, {(KB-1){1'b0}}};
            1: c[k] = {1'b0, {(KB-1){1'b1}}};
            2: c[k] = '1;
            default: c[k] = '0;
          endcase
        end
      endcase
    end
    return CFG_W'({c[2], c[1], c[0]});
  endfunction

  function automatic logic [CFG_W-1:0] pick_bounds();
    int lo, hi;
    case ($urandom_range(9))
      0: begin   // empty range
        lo = int'($urandom_range(500)) + 1;
        hi = lo - 1 - int'($urandom_range(500));
      end
      1: begin
        lo = -(1 << (CB - 1));
        hi = (1 << (CB - 1)) - 1;
      end
      2: begin
        lo = (1 << (CB - 1)) - 1;
        hi = lo;
      end
      default: begin
        lo = -int'($urandom_range(4000));
        hi = int'($urandom_range(4000));
      end
    endcase
    return range2(lo, hi);
  endfunction

  function automatic logic [CFG_W-1:0] pick_min_points();
    case ($urandom_range(9))
      0: return '0;
      1: return CFG_W'({MIN_PTS_BITS{1'b1}});
      2: return CFG_W'(CAP);
      default: return CFG_W'($urandom_range(6, 1));
    endcase
  endfunction

  // fresh settings, then mostly points around the origin with some noise
  task automatic run_random_phase(input int n_points, input int style);
    int ox, oy, oz;
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    write_reg(REG_ROT_ROW0, pick_row(style, 0));
    write_reg(REG_ROT_ROW1, pick_row(style, 1));
    write_reg(REG_ROT_ROW2, pick_row(style, 2));
    write_reg(REG_BOX_ORIGIN, raw[3*CB-1:0]);
    write_reg(REG_X_BOUNDS, pick_bounds());
    write_reg(REG_Y_BOUNDS, pick_bounds());
    write_reg(REG_Z_BOUNDS, pick_bounds());
    write_reg(REG_MIN_POINTS, pick_min_points());
    ox = int'($signed(origin_m[CB-1:0]));
    oy = int'($signed(origin_m[2*CB-1:CB]));
    oz = int'($signed(origin_m[3*CB-1:2*CB]));
    for (int i = 0; i < n_points; i++) begin
      if ($urandom_range(99) < 80) begin
        queue_point(ox + int'($urandom_range(6000)) - 3000,
                    oy + int'($urandom_range(6000)) - 3000,
                    oz + int'($urandom_range(6000)) - 3000,
                    $urandom_range(11) == 0);
      end else begin
        queue_point(int'($urandom), int'($urandom), int'($urandom),
                    $urandom_range(11) == 0);
      end
    end
    wait_idle();
  endtask

  // input side: hold a word until taken, then maybe idle, then send the next
  always @(negedge clk) begin
    lidar_point_t p;
    if (!rst_n) begin
      in_tvalid  <= 1'b0;
      out_tready <= 1'b0;
    end else begin
      if (!in_tvalid || point_taken) begin
        point_taken = 1'b0;
        if (point_queue.size() != 0 && !idle_roll()) begin
          p = point_queue[0];
          point_queue.delete(0);
          in_tvalid <= 1'b1;
          in_tdata  <= {{(IN_W - 3*CB){1'b0}}, p.pz, p.py, p.px};
          in_tlast  <= p.last;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      // result side stalls on its own schedule
      out_tready <= !idle_roll();
    end
  end

  // both handshakes sampled at the rising edge, before the block updates
  always @(posedge clk) begin
    lidar_point_t p;
    box_verdict_t v;
    cycle_count++;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        p.px   = in_tdata[CB-1:0];
        p.py   = in_tdata[2*CB-1:CB];
        p.pz   = in_tdata[3*CB-1:2*CB];
        p.last = in_tlast;
        classify_point(p);
        point_taken = 1'b1;
        points_left--;
      end
      if (out_tvalid && out_tready) begin
        if (verdicts_due.size() == 0) begin
          report_mismatch("unexpected result word", 0, out_tdata);
        end else begin
          v = verdicts_due[0];
          verdicts_due.delete(0);
          if (out_tdata[0] !== v.in_box) report_mismatch("inside_res", v.in_box, out_tdata[0]);
          if (out_tdata[COUNT_OUT_BITS:1] !== v.tally)
            report_mismatch("running_count", v.tally, out_tdata[COUNT_OUT_BITS:1]);
          if (out_tlast !== v.done) report_mismatch("frame_done", v.done, out_tlast);
          if (out_tdata[COUNT_OUT_BITS+1] !== v.obstacle)
            report_mismatch("obstacle", v.obstacle, out_tdata[COUNT_OUT_BITS+1]);
        end
      end
    end
    if (cycle_count > LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("** oriented_box_point_counter_core: FAILED **");
      $finish;
    end
  end

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tlast   = 1'b0;
    out_tready = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = REG_ROT_ROW0;
    cfg_wdata  = '0;
    // register values right after reset: identity rotation, all else zero, min one
    rot_m[0]     = 48'h0000_0000_4000;
    rot_m[1]     = 48'h0000_4000_0000;
    rot_m[2]     = 48'h4000_0000_0000;
    origin_m     = '0;
    bounds_m[0]  = '0;
    bounds_m[1]  = '0;
    bounds_m[2]  = '0;
    min_points_m = 1;
    frame_count  = '0;
    repeat (2) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // reset settings: only the origin itself is in the degenerate box
    queue_point(0, 0, 0, 1'b0);
    queue_point(1, 0, 0, 1'b1);
    wait_idle();

    // axis-aligned box around an offset origin, edges hit exactly
    write_reg(REG_ROT_ROW0, row3(1 << FB, 0, 0));
    write_reg(REG_ROT_ROW1, row3(0, 1 << FB, 0));
    write_reg(REG_ROT_ROW2, row3(0, 0, 1 << FB));
    write_reg(REG_BOX_ORIGIN, xyz(1000, -2000, 300));
    write_reg(REG_X_BOUNDS, range2(-100, 100));
    write_reg(REG_Y_BOUNDS, range2(-50, 50));
    write_reg(REG_Z_BOUNDS, range2(0, 200));
    write_reg(REG_MIN_POINTS, CFG_W'(3));
    queue_point(1000, -2000, 300, 1'b0);
    queue_point(1100, -1950, 500, 1'b0);
    queue_point(900, -2050, 300, 1'b0);
    queue_point(1101, -2000, 300, 1'b0);
    queue_point(1000, -2051, 300, 1'b0);
    queue_point(1000, -2000, 299, 1'b0);
    queue_point(131071, 131071, 131071, 1'b0);
    queue_point(-131072, -131072, -131072, 1'b1);
    wait_idle();

    // quarter turn about z: local x follows dy, local y follows -dx
    write_reg(REG_ROT_ROW0, row3(0, 1 << FB, 0));
    write_reg(REG_ROT_ROW1, row3(-(1 << FB), 0, 0));
    queue_point(1050, -1980, 310, 1'b0);
    queue_point(1051, -1980, 310, 1'b0);
    queue_point(1000, -1899, 300, 1'b1);
    wait_idle();

    // min above max empties the x range; min_points zero still flags the frame
    write_reg(REG_X_BOUNDS, range2(50, -50));
    write_reg(REG_MIN_POINTS, CFG_W'(0));
    queue_point(1000, -2000, 300, 1'b1);
    wait_idle();

    // whole-range box, two full frames, each with no idling
    calm = 1'b1;
    write_reg(REG_ROT_ROW0, row3(1 << FB, 0, 0));
    write_reg(REG_ROT_ROW1, row3(0, 1 << FB, 0));
    write_reg(REG_BOX_ORIGIN, CFG_W'(0));
    write_reg(REG_X_BOUNDS, range2(-(1 << (CB - 1)), (1 << (CB - 1)) - 1));
    write_reg(REG_Y_BOUNDS, range2(-(1 << (CB - 1)), (1 << (CB - 1)) - 1));
    write_reg(REG_Z_BOUNDS, range2(-(1 << (CB - 1)), (1 << (CB - 1)) - 1));
    write_reg(REG_MIN_POINTS, CFG_W'(CALM_POINTS));
    for (int i = 0; i < CALM_POINTS; i++) begin
      queue_point(int'($urandom), int'($urandom), int'($urandom), i == CALM_POINTS - 1);
    end
    wait_idle();
    // same again with the threshold one past the frame size: no obstacle
    write_reg(REG_MIN_POINTS, CFG_W'(CALM_POINTS + 1));
    for (int i = 0; i < CALM_POINTS; i++) begin
      queue_point(int'($urandom), int'($urandom), int'($urandom), i == CALM_POINTS - 1);
    end
    wait_idle();
    calm = 1'b0;

    // random settings and points, cycling through the rotation flavors
    for (int ph = 0; ph < 7; ph++) begin
      run_random_phase(200, ph % 4);
    end

    repeat (10) @(negedge clk);
    if (mismatches == 0) begin
      $display("** oriented_box_point_counter_core: PASSED **");
    end else begin
      $display("** oriented_box_point_counter_core: FAILED **");
    end
    $finish;
  end

endmodule
